// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define AST_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every clock edge, reset included.
`define AST_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/vwto_pkg.sv =====
// ----------------------------------------------------------------------------
// vwto_pkg
// Shared types and constants of the triangle oscillator.
// ----------------------------------------------------------------------------
package vwto_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int CH_W         = 3;   // channel field width
  localparam int CH_EXT_W     = 7;   // holds any channel count up to 127
  localparam int PHASE_W      = 32;
  localparam int WIDTH_W      = 16;
  localparam int SAMPLE_W     = 16;
  localparam int DIV_STEPS    = 16;  // quotient bits
  localparam int DCNT_W       = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [WIDTH_W-1:0] RISE_WIDTH_RST = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_INC  = 1'b0,
    REG_RISE_WIDTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FIN
  } vwto_state_t;

  typedef struct packed {
    logic load;    // capture request, read phase
    logic setup;   // pick branch, update phase, start divider
    logic step;    // one quotient bit
    logic finish;  // form sample into output register
  } vwto_cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_free;
  } vwto_sts_t;

endpackage

// ===== rtl/vwto_ctrl.sv =====
// ----------------------------------------------------------------------------
// vwto_ctrl
// Sequencer: request capture, setup, sixteen divide steps, output load.
// ----------------------------------------------------------------------------
module vwto_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output vwto_pkg::vwto_cmd_t cmd,
  input  vwto_pkg::vwto_sts_t sts
);
  import vwto_pkg::*;

  vwto_state_t state;
  vwto_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = rst || (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/vwto_dp.sv =====
// ----------------------------------------------------------------------------
// vwto_dp
// Config registers, phase memory, restoring divider and output register.
// ----------------------------------------------------------------------------
module vwto_dp #(
  parameter int CHANNELS = vwto_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [vwto_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vwto_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [vwto_pkg::CH_W-1:0]           channel,
  input  vwto_pkg::vwto_cmd_t                 cmd,
  output vwto_pkg::vwto_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [vwto_pkg::SAMPLE_W-1:0] sample_out,
  output logic [vwto_pkg::CH_W-1:0]           channel_out
);
  import vwto_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // config
  logic [PHASE_W-1:0] phase_inc;
  logic [WIDTH_W-1:0] rise_width;

  // request
  logic [CH_W-1:0]     ch_reg;
  logic [IDX_W-1:0]    idx_reg;
  logic                in_rng;
  logic [CH_EXT_W-1:0] ch_ext;
  logic [IDX_W-1:0]    idx;
  logic                rng;

  // phase memory with per-entry valid bits
  logic [PHASE_W-1:0]  phase_mem [CHANNELS];
  logic [CHANNELS-1:0] vld_bits;
  logic [PHASE_W-1:0]  rd_data;
  logic                rd_vld;
  logic [PHASE_W-1:0]  phase;
  logic [PHASE_W-1:0]  width_q32;
  logic                rise_now;

  // divider
  logic                rising;
  logic [WIDTH_W:0]    dsr;
  logic [WIDTH_W:0]    rem;
  logic [DIV_STEPS-1:0] nq;
  logic [DCNT_W-1:0]   dcnt;
  logic [WIDTH_W:0]    trial;
  logic                q_bit;
  logic [PHASE_W-1:0]  num;

  logic [SAMPLE_W-1:0] sample_new;

  assign ch_ext = {{(CH_EXT_W-CH_W){1'b0}}, channel};
  assign idx    = ch_ext[IDX_W-1:0];
  assign rng    = ch_ext < CH_EXT_W'(CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc  <= '0;
      rise_width <= RISE_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_INC:  phase_inc  <= cfg_data;
        REG_RISE_WIDTH: rise_width <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_reg  <= channel;
      idx_reg <= idx;
      in_rng  <= rng;
    end
  end

  // memory: registered read on load, write of the advanced phase on setup
  always_ff @(posedge clk) begin
    if (cmd.load && rng) begin
      rd_data <= phase_mem[idx];
    end
    if (cmd.setup && in_rng) begin
      phase_mem[idx_reg] <= phase + phase_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_bits <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_vld <= rng && vld_bits[idx];
      end
      if (cmd.setup && in_rng) begin
        vld_bits[idx_reg] <= 1'b1;
      end
    end
  end

  assign phase     = rd_vld ? rd_data : '0;
  assign width_q32 = {rise_width, {(PHASE_W-WIDTH_W){1'b0}}};
  assign rise_now  = phase < width_q32;
  // both branches reduce to a 32-bit by 17-bit divide with a 16-bit quotient
  assign num       = rise_now ? phase : (phase - width_q32);

  assign trial = {rem[WIDTH_W-1:0], nq[DIV_STEPS-1]};
  assign q_bit = trial >= dsr;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rising <= rise_now;
      dsr    <= rise_now ? {1'b0, rise_width}
                         : ((WIDTH_W+1)'(1) << WIDTH_W) - {1'b0, rise_width};
      rem    <= {1'b0, num[PHASE_W-1:DIV_STEPS]};
      nq     <= num[DIV_STEPS-1:0];
    end else if (cmd.step) begin
      rem <= q_bit ? (trial - dsr) : trial;
      nq  <= {nq[DIV_STEPS-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.setup) begin
      dcnt <= '0;
    end else if (cmd.step) begin
      dcnt <= dcnt + 1'b1;
    end
  end

  assign sts.last_step = dcnt == DCNT_W'(DIV_STEPS - 1);
  assign sts.out_free  = !out_valid || !out_stall;

  // rising: q - 1.0; falling: 1.0 - q, peak clipped to full scale
  always_comb begin
    if (!in_rng) begin
      sample_new = '0;
    end else if (rising) begin
      sample_new = {~nq[DIV_STEPS-1], nq[DIV_STEPS-2:0]};
    end else if (nq == '0) begin
      sample_new = 16'h7FFF;
    end else begin
      sample_new = 16'h8000 - nq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_out  <= sample_new;
      channel_out <= ch_reg;
    end
  end

endmodule

// ===== rtl/variable_width_triangle_oscillator.sv =====
// ----------------------------------------------------------------------------
// variable_width_triangle_oscillator
// Multi-channel triangle oscillator with adjustable rise/fall symmetry.
// ----------------------------------------------------------------------------
// Each request names a channel; the block returns that channel's sample in
// signed Q1.15, taken from the phase before the update, then advances the
// phase by phase_increment (Q0.32, wraps). While the phase is below
// rise_width (Q0.16) the sample ramps from -1 up to +1, and over the rest of
// the cycle it ramps back down; the peak clips to 32767. rise_width 0 gives a
// pure falling ramp. A channel at or beyond CHANNELS returns 0 and touches
// no phase. The phase memory is read at the accepting edge. A setup step
// then selects the branch and writes back the advanced phase, the
// one-bit-per-cycle restoring divider forms the 16-bit ramp position,
// and the result loads into the output register once that register is
// free. The sequencer then returns to idle and can accept the next request.
// in_stall stays high from acceptance until the output register
// loads, and longer while a stalled result still holds that register.
// The output register lets a finished sample wait while the next request
// is accepted. Phases read as zero after reset (per-entry valid bits), so
// no clearing pass is needed. Configuration writes are always taken
// (cfg_ready is high outside reset) and should only be made while idle.
// ----------------------------------------------------------------------------
module variable_width_triangle_oscillator #(
  parameter int CHANNELS = vwto_pkg::CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vwto_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vwto_pkg::CFG_DATA_W-1:0]      cfg_data,
  // sample requests
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [vwto_pkg::CH_W-1:0]            channel,
  // samples
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [vwto_pkg::SAMPLE_W-1:0] sample_out,
  output logic [vwto_pkg::CH_W-1:0]            channel_out
);
  import vwto_pkg::*;

  vwto_cmd_t cmd;
  vwto_sts_t sts;

  assign cfg_ready = !rst;

  // sequencer
  vwto_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // phase store, divider, output register
  vwto_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .channel     (channel),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .channel_out (channel_out)
  );

endmodule

// ===== rtl/vwto_checker.sv =====
// ----------------------------------------------------------------------------
// vwto_checker
// Port-level checks of the triangle oscillator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vwto_checker #(
  parameter int CHANNELS = vwto_pkg::CHANNELS_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [vwto_pkg::SAMPLE_W-1:0] sample_out,
  input logic [vwto_pkg::CH_W-1:0]            channel_out
);
  import vwto_pkg::*;

  logic in_acc;
  logic ch_out_of_range;

  assign in_acc          = in_valid && !in_stall;
  assign ch_out_of_range = {{(CH_EXT_W-CH_W){1'b0}}, channel_out} >= CH_EXT_W'(CHANNELS);

  // a stalled result stays offered
  `AST_CLK(a_out_hold, out_valid && out_stall |=> out_valid)
  // one item at a time: busy right after acceptance
  `AST_CLK(a_busy_after_acc, in_acc |=> in_stall)
  // the input is still closed at the last divide step
  `AST_CLK(a_busy_span, in_acc |-> ##17 in_stall)
  // channels without a phase produce silence
  `AST_CLK(a_oor_silent, out_valid && ch_out_of_range |-> sample_out == '0)
  // reset empties the output register
  `AST_ALWAYS(a_rst_clears, rst |=> !out_valid)

endmodule

bind variable_width_triangle_oscillator vwto_checker #(.CHANNELS(CHANNELS)) u_vwto_checker (.*);
